[rtl/sfla_pkg.sv]
// Shared opcodes, status codes, allocator constants and the size-class function.
package sfla_pkg;

  localparam int unsigned HEAP_BYTES_DEF   = 65536;
  localparam int unsigned SIZE_CLASSES_DEF = 10;

  localparam int unsigned OPC_W  = 2;
  localparam int unsigned REQ_W  = 17;
  localparam int unsigned ADDR_W = 16;
  localparam int unsigned STS_W  = 2;
  localparam int unsigned WORD_W = 32;

  localparam logic [OPC_W-1:0] OP_INIT  = 2'd0;
  localparam logic [OPC_W-1:0] OP_ALLOC = 2'd1;
  localparam logic [OPC_W-1:0] OP_FREE  = 2'd2;

  localparam logic [STS_W-1:0] ST_OK      = 2'd0;
  localparam logic [STS_W-1:0] ST_NOSPACE = 2'd1;
  localparam logic [STS_W-1:0] ST_ZERO    = 2'd2;

  localparam logic [WORD_W-1:0] FIRST_GROW   = 32'd256;
  localparam logic [WORD_W-1:0] MIN_GROW     = 32'd64;
  localparam logic [WORD_W-1:0] SPLIT_MIN    = 32'd16;
  localparam logic [WORD_W-1:0] HDR_ROUND    = 32'd15;  // 8 bytes of tags plus 7 for rounding
  localparam logic [WORD_W-1:0] PROLOGUE_TAG = 32'd9;   // 8 bytes, allocated
  localparam logic [WORD_W-1:0] EPILOGUE_TAG = 32'd1;   // zero size, allocated
  localparam logic [WORD_W-1:0] SIZE_MASK    = ~32'd7;

  // Class 0 holds sizes below 16, class n holds 2^(n+3)..2^(n+4)-1; the last class takes everything larger.
  function automatic logic [3:0] class_of(input logic [WORD_W-1:0] size,
                                          input int unsigned sc);
    logic [3:0] n;
    n = '0;
    for (int i = 0; i < 15; i++) begin
      if ((i < int'(sc) - 1) && ((size >> (i + 4)) != '0)) n = n + 4'd1;
    end
    return n;
  endfunction

endpackage

[rtl/segregated_free_list_allocator_core.sv]
// Segregated free-list heap allocator: sequencer around a tag memory.
// Init writes the prologue and epilogue, then grows the heap; refused or ignored items go straight
//   to the result; a free whose tags fail ends after the checks, else it coalesces and is pushed;
//   alloc scans class lists upward for a first fit, growing the heap if none, then places it whole or split.
// Throughput: one item at a time, input stalls until the result register is loaded.
// Reset clears the sequencer, list heads and heap break; tag memory is not cleared.
module segregated_free_list_allocator_core import sfla_pkg::*; #(
  parameter int unsigned HEAP_BYTES   = HEAP_BYTES_DEF,   // power of two
  parameter int unsigned SIZE_CLASSES = SIZE_CLASSES_DEF
) (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  input  logic [OPC_W-1:0]  in_opcode,
  input  logic [REQ_W-1:0]  in_request_bytes,
  input  logic [ADDR_W-1:0] in_block_address,
  output logic              out_valid,
  input  logic              out_stall,
  output logic [ADDR_W-1:0] out_payload_address,
  output logic [STS_W-1:0]  out_status
);

  localparam int unsigned TAG_WORDS = HEAP_BYTES / 4;
  localparam int unsigned IW        = $clog2(TAG_WORDS);
  localparam int unsigned BKW       = $clog2(HEAP_BYTES) + 1;
  localparam int unsigned CW        = (SIZE_CLASSES > 1) ? $clog2(SIZE_CLASSES) : 1;
  localparam int unsigned BGW       = IW + 1;
  localparam logic [WORD_W-1:0] HEAP_W   = WORD_W'(HEAP_BYTES);
  localparam logic [CW-1:0]     LAST_CLS = CW'(SIZE_CLASSES - 1);
  localparam bit INIT_FITS = (HEAP_BYTES >= 272);   // prologue area plus first growth

  typedef enum logic [5:0] {
    S_IDLE, S_I0, S_I1, S_I2, S_I3,
    S_GROW, S_G1, S_G2, S_G3,
    S_C0, S_C1, S_C2, S_C3, S_C4, S_C5, S_C6,
    S_P0, S_P1, S_P2,
    S_U0, S_U1, S_U2, S_U3,
    S_F0, S_FCHK, S_F1, S_F2,
    S_L0, S_L1, S_L2, S_L3, S_L4, S_L5, S_L7,
    S_R0, S_R1, S_R2, S_R3,
    S_DONE
  } state_t;

  state_t state_r, state_nxt, unl_ret_r, unl_ret_nxt, coal_ret_r, coal_ret_nxt;
  logic [WORD_W-1:0] asize_r, asize_nxt, bp_r, bp_nxt, csize_r, csize_nxt;
  logic [WORD_W-1:0] pw_r, pw_nxt, hw_r, hw_nxt, ub_r, ub_nxt, up_r, up_nxt, us_r, us_nxt;
  logic [ADDR_W-1:0] res_r, res_nxt;
  logic [STS_W-1:0]  sts_r, sts_nxt;
  logic [BKW-1:0]    brk_r, brk_nxt;
  logic [BGW-1:0]    budget_r, budget_nxt;
  logic [CW-1:0]     cls_r, cls_nxt;
  logic [ADDR_W-1:0] heads_r [SIZE_CLASSES];
  logic              head_we, heads_clr;
  logic [ADDR_W-1:0] head_wd;
  logic              out_valid_r, out_valid_nxt;
  logic [ADDR_W-1:0] out_addr_r, out_addr_nxt;
  logic [STS_W-1:0]  out_sts_r, out_sts_nxt;

  // tag memory, one word per 4 heap bytes
  logic [WORD_W-1:0] tag_mem [TAG_WORDS];
  logic [WORD_W-1:0] mem_q;
  logic              mem_we;
  logic [WORD_W-1:0] mem_wa, mem_ra, mem_wd;

  logic [WORD_W-1:0] q_size, pw_size, brk_w, head_w, asize_calc, grow_bytes;
  logic              accept;

  assign q_size     = mem_q & SIZE_MASK;
  assign pw_size    = pw_r & SIZE_MASK;
  assign brk_w      = WORD_W'(brk_r);
  assign head_w     = WORD_W'(heads_r[cls_r]);
  assign asize_calc = (WORD_W'(in_request_bytes) + HDR_ROUND) & SIZE_MASK;
  assign grow_bytes = (asize_r > MIN_GROW) ? asize_r : MIN_GROW;
  assign in_stall   = (state_r != S_IDLE);
  assign accept     = in_valid && !in_stall;

  always_ff @(posedge clk) begin
    if (mem_we) tag_mem[mem_wa[IW+1:2]] <= mem_wd;
    mem_q <= tag_mem[mem_ra[IW+1:2]];
  end

  always_comb begin
    state_nxt = state_r;   unl_ret_nxt = unl_ret_r; coal_ret_nxt = coal_ret_r;
    asize_nxt = asize_r;   bp_nxt = bp_r;
    csize_nxt = csize_r;   pw_nxt = pw_r;           hw_nxt = hw_r;
    ub_nxt = ub_r;         up_nxt = up_r;           us_nxt = us_r;
    res_nxt = res_r;       sts_nxt = sts_r;         brk_nxt = brk_r;
    budget_nxt = budget_r; cls_nxt = cls_r;
    head_we = 1'b0; head_wd = '0; heads_clr = 1'b0;
    mem_we = 1'b0; mem_wa = '0; mem_wd = '0; mem_ra = '0;
    out_valid_nxt = out_valid_r && out_stall;
    out_addr_nxt = out_addr_r; out_sts_nxt = out_sts_r;

    case (state_r)
      S_IDLE: begin
        if (accept) begin
          res_nxt = '0; sts_nxt = ST_OK;
          case (in_opcode)
            OP_INIT: begin
              brk_nxt = '0; heads_clr = 1'b1;
              if (INIT_FITS) state_nxt = S_I0;
              else begin
                sts_nxt = ST_NOSPACE; state_nxt = S_DONE;
              end
            end
            OP_ALLOC: begin
              if (in_request_bytes == '0) begin
                sts_nxt = ST_ZERO; state_nxt = S_DONE;
              end else if (brk_r == '0) begin
                sts_nxt = ST_NOSPACE; state_nxt = S_DONE;
              end else begin
                asize_nxt  = asize_calc;
                cls_nxt    = CW'(class_of(asize_calc, SIZE_CLASSES));
                budget_nxt = BGW'(TAG_WORDS);
                state_nxt  = S_F0;
              end
            end
            OP_FREE: begin
              bp_nxt = WORD_W'(in_block_address);
              if ((in_block_address[2:0] != 3'd0) || (in_block_address < 16'd16) ||
                  (WORD_W'(in_block_address) >= brk_w))
                state_nxt = S_DONE;
              else state_nxt = S_R0;
            end
            default: state_nxt = S_DONE;
          endcase
        end
      end
      // prologue and epilogue
      S_I0: begin mem_we = 1'b1; mem_wa = 32'd0;  mem_wd = '0;           state_nxt = S_I1; end
      S_I1: begin mem_we = 1'b1; mem_wa = 32'd4;  mem_wd = PROLOGUE_TAG; state_nxt = S_I2; end
      S_I2: begin mem_we = 1'b1; mem_wa = 32'd8;  mem_wd = PROLOGUE_TAG; state_nxt = S_I3; end
      S_I3: begin
        mem_we = 1'b1; mem_wa = 32'd12; mem_wd = EPILOGUE_TAG;
        brk_nxt = BKW'(16); csize_nxt = FIRST_GROW; coal_ret_nxt = S_DONE;
        state_nxt = S_GROW;
      end
      // heap growth by csize_r bytes
      S_GROW: begin
        bp_nxt = brk_w;
        if ((brk_r == '0) || (csize_r > HEAP_W - brk_w)) begin
          sts_nxt = ST_NOSPACE; res_nxt = '0; state_nxt = S_DONE;
        end else state_nxt = S_G1;
      end
      S_G1: begin mem_we = 1'b1; mem_wa = bp_r - 32'd4; mem_wd = csize_r; state_nxt = S_G2; end
      S_G2: begin
        mem_we = 1'b1; mem_wa = bp_r + csize_r - 32'd8; mem_wd = csize_r; state_nxt = S_G3;
      end
      S_G3: begin
        mem_we = 1'b1; mem_wa = bp_r + csize_r - 32'd4; mem_wd = EPILOGUE_TAG;
        brk_nxt = BKW'(bp_r + csize_r); state_nxt = S_C0;
      end
      // coalesce bp_r with free neighbors, then push
      S_C0: begin mem_ra = bp_r - 32'd4; state_nxt = S_C1; end
      S_C1: begin csize_nxt = q_size; mem_ra = bp_r - 32'd8; state_nxt = S_C2; end
      S_C2: begin pw_nxt = mem_q; mem_ra = bp_r + csize_r - 32'd4; state_nxt = S_C3; end
      S_C3: begin
        if (!mem_q[0]) begin
          ub_nxt = bp_r + csize_r;
          cls_nxt = CW'(class_of(q_size, SIZE_CLASSES));
          csize_nxt = csize_r + q_size;
          unl_ret_nxt = S_C4; state_nxt = S_U0;
        end else state_nxt = S_C4;
      end
      S_C4: begin
        if (!pw_r[0]) begin
          ub_nxt = bp_r - pw_size; bp_nxt = bp_r - pw_size;
          cls_nxt = CW'(class_of(pw_size, SIZE_CLASSES));
          csize_nxt = csize_r + pw_size;
          unl_ret_nxt = S_C5; state_nxt = S_U0;
        end else state_nxt = S_C5;
      end
      S_C5: begin mem_we = 1'b1; mem_wa = bp_r - 32'd4; mem_wd = csize_r; state_nxt = S_C6; end
      S_C6: begin
        mem_we = 1'b1; mem_wa = bp_r + csize_r - 32'd8; mem_wd = csize_r;
        cls_nxt = CW'(class_of(csize_r, SIZE_CLASSES)); state_nxt = S_P0;
      end
      // push at list head
      S_P0: begin up_nxt = head_w; mem_we = 1'b1; mem_wa = bp_r; mem_wd = '0; state_nxt = S_P1; end
      S_P1: begin mem_we = 1'b1; mem_wa = bp_r + 32'd4; mem_wd = up_r; state_nxt = S_P2; end
      S_P2: begin
        if (up_r != '0) begin
          mem_we = 1'b1; mem_wa = up_r; mem_wd = bp_r;
        end
        head_we = 1'b1; head_wd = bp_r[ADDR_W-1:0];
        state_nxt = coal_ret_r;
      end
      // unlink ub_r from class cls_r
      S_U0: begin mem_ra = ub_r; state_nxt = S_U1; end
      S_U1: begin up_nxt = mem_q; mem_ra = ub_r + 32'd4; state_nxt = S_U2; end
      S_U2: begin
        us_nxt = mem_q;
        if (up_r == '0) begin
          head_we = 1'b1; head_wd = mem_q[ADDR_W-1:0];
        end else begin
          mem_we = 1'b1; mem_wa = up_r + 32'd4; mem_wd = mem_q;
        end
        state_nxt = S_U3;
      end
      S_U3: begin
        if (us_r != '0) begin
          mem_we = 1'b1; mem_wa = us_r; mem_wd = up_r;
        end
        state_nxt = unl_ret_r;
      end
      // first fit from class cls_r upward
      S_F0: begin bp_nxt = head_w; state_nxt = S_FCHK; end
      S_FCHK: begin
        if (bp_r == '0) begin
          if (cls_r == LAST_CLS) begin
            csize_nxt = grow_bytes; coal_ret_nxt = S_L0; state_nxt = S_GROW;
          end else begin
            cls_nxt = cls_r + 1'b1; state_nxt = S_F0;
          end
        end else if (budget_r == '0) begin
          csize_nxt = grow_bytes; coal_ret_nxt = S_L0; state_nxt = S_GROW;
        end else begin
          budget_nxt = budget_r - 1'b1; mem_ra = bp_r - 32'd4; state_nxt = S_F1;
        end
      end
      S_F1: begin
        if (q_size >= asize_r) state_nxt = S_L0;
        else begin
          mem_ra = bp_r + 32'd4; state_nxt = S_F2;
        end
      end
      S_F2: begin bp_nxt = mem_q; state_nxt = S_FCHK; end
      // place asize_r in block bp_r
      S_L0: begin res_nxt = bp_r[ADDR_W-1:0]; mem_ra = bp_r - 32'd4; state_nxt = S_L1; end
      S_L1: begin
        csize_nxt = q_size; ub_nxt = bp_r;
        cls_nxt = CW'(class_of(q_size, SIZE_CLASSES));
        unl_ret_nxt = S_L2; state_nxt = S_U0;
      end
      S_L2: begin
        mem_we = 1'b1; mem_wa = bp_r - 32'd4;
        if (csize_r >= asize_r + SPLIT_MIN) begin
          mem_wd = asize_r | 32'd1; state_nxt = S_L3;
        end else begin
          mem_wd = csize_r | 32'd1; state_nxt = S_L7;
        end
      end
      S_L3: begin
        mem_we = 1'b1; mem_wa = bp_r + asize_r - 32'd8; mem_wd = asize_r | 32'd1;
        state_nxt = S_L4;
      end
      S_L4: begin
        mem_we = 1'b1; mem_wa = bp_r + asize_r - 32'd4; mem_wd = csize_r - asize_r;
        state_nxt = S_L5;
      end
      S_L5: begin
        mem_we = 1'b1; mem_wa = bp_r + csize_r - 32'd8; mem_wd = csize_r - asize_r;
        bp_nxt = bp_r + asize_r; coal_ret_nxt = S_DONE; state_nxt = S_C0;
      end
      S_L7: begin
        mem_we = 1'b1; mem_wa = bp_r + csize_r - 32'd8; mem_wd = csize_r | 32'd1;
        state_nxt = S_DONE;
      end
      // free with header and footer checks
      S_R0: begin mem_ra = bp_r - 32'd4; state_nxt = S_R1; end
      S_R1: begin
        hw_nxt = mem_q; csize_nxt = q_size;
        mem_ra = bp_r + q_size - 32'd8;
        if (!mem_q[0] || (q_size < SPLIT_MIN) || (q_size > brk_w - bp_r)) state_nxt = S_DONE;
        else state_nxt = S_R2;
      end
      S_R2: begin
        if (mem_q != hw_r) state_nxt = S_DONE;
        else begin
          mem_we = 1'b1; mem_wa = bp_r - 32'd4; mem_wd = csize_r; state_nxt = S_R3;
        end
      end
      S_R3: begin
        mem_we = 1'b1; mem_wa = bp_r + csize_r - 32'd8; mem_wd = csize_r;
        coal_ret_nxt = S_DONE; state_nxt = S_C0;
      end
      S_DONE: begin
        if (!out_valid_r || !out_stall) begin
          out_valid_nxt = 1'b1; out_addr_nxt = res_r; out_sts_nxt = sts_r;
          state_nxt = S_IDLE;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE; unl_ret_r <= S_IDLE; coal_ret_r <= S_IDLE;
      brk_r <= '0; out_valid_r <= 1'b0;
      for (int i = 0; i < SIZE_CLASSES; i++) heads_r[i] <= '0;
    end else begin
      state_r <= state_nxt; unl_ret_r <= unl_ret_nxt; coal_ret_r <= coal_ret_nxt;
      brk_r <= brk_nxt; out_valid_r <= out_valid_nxt;
      if (heads_clr) begin
        for (int i = 0; i < SIZE_CLASSES; i++) heads_r[i] <= '0;
      end else if (head_we) heads_r[cls_r] <= head_wd;
    end
    asize_r <= asize_nxt; bp_r <= bp_nxt; csize_r <= csize_nxt;
    pw_r <= pw_nxt; hw_r <= hw_nxt; ub_r <= ub_nxt; up_r <= up_nxt; us_r <= us_nxt;
    res_r <= res_nxt; sts_r <= sts_nxt; budget_r <= budget_nxt; cls_r <= cls_nxt;
    out_addr_r <= out_addr_nxt; out_sts_r <= out_sts_nxt;
  end

  assign out_valid           = out_valid_r;
  assign out_payload_address = out_addr_r;
  assign out_status          = out_sts_r;

endmodule

[verif/tb_segregated_free_list_allocator_core.sv]
// Testbench for the segregated free-list allocator core: directed and random heap traffic.
module tb_segregated_free_list_allocator_core;
  import sfla_pkg::*;

  localparam int unsigned HEAP   = HEAP_BYTES_DEF;
  localparam int unsigned NCLASS = SIZE_CLASSES_DEF;
  localparam int unsigned NWORDS = HEAP / 4;

  logic              clk;
  logic              rst_n;
  logic              in_valid;
  logic              in_stall;
  logic [OPC_W-1:0]  in_opcode;
  logic [REQ_W-1:0]  in_request_bytes;
  logic [ADDR_W-1:0] in_block_address;
  logic              out_valid;
  logic              out_stall;
  logic [ADDR_W-1:0] out_payload_address;
  logic [STS_W-1:0]  out_status;

  segregated_free_list_allocator_core uut (
    .clk                 (clk),
    .rst_n               (rst_n),
    .in_valid            (in_valid),
    .in_stall            (in_stall),
    .in_opcode           (in_opcode),
    .in_request_bytes    (in_request_bytes),
    .in_block_address    (in_block_address),
    .out_valid           (out_valid),
    .out_stall           (out_stall),
    .out_payload_address (out_payload_address),
    .out_status          (out_status)
  );

  typedef struct packed {
    logic [ADDR_W-1:0] addr;
    logic [STS_W-1:0]  status;
  } alloc_result_t;

  // Shadow heap: tag words, which words were ever written, list heads, break.
  logic [31:0]  shadow_tags [NWORDS];
  bit           tag_written [NWORDS];
  int unsigned  list_head [NCLASS];
  int unsigned  brk;

  alloc_result_t   pending_results [$];
  logic [15:0]     live_blocks [$];   // payloads currently handed out
  int              errors;
  bit              calm;              // no idling on either side while set

  always #1 clk = ~clk;

  // ---------------------------------------------------------------- predictor
  function automatic logic [31:0] tag_rd(int unsigned a);
    return shadow_tags[(a >> 2) % NWORDS];
  endfunction

  function automatic void tag_wr(int unsigned a, logic [31:0] v);
    shadow_tags[(a >> 2) % NWORDS] = v;
    tag_written[(a >> 2) % NWORDS] = 1'b1;
  endfunction

  // size class: below 16 is class 0, then one class per power of two
  function automatic int unsigned size_class(int unsigned sz);
    int unsigned n;
    n = 0;
    while (n < NCLASS - 1 && (sz >> (n + 4)) != 0) n++;
    return n;
  endfunction

  function automatic void list_push(int unsigned c, int unsigned bp);
    int unsigned head;
    head = list_head[c];
    tag_wr(bp, 0);
    tag_wr(bp + 4, head);
    if (head != 0) tag_wr(head, bp);
    list_head[c] = bp;
  endfunction

  function automatic void list_unlink(int unsigned bp, int unsigned c);
    int unsigned p, s;
    p = tag_rd(bp);
    s = tag_rd(bp + 4);
    if (p == 0) list_head[c] = s;
    else tag_wr(p + 4, s);
    if (s != 0) tag_wr(s, p);
  endfunction

  function automatic int unsigned merge_free(int unsigned bp);
    int unsigned csize, pw, nw, nxt, ns, ps;
    csize = tag_rd(bp - 4) & ~32'd7;
    pw    = tag_rd(bp - 8);
    nxt   = bp + csize;
    nw    = tag_rd(nxt - 4);
    if (!nw[0]) begin
      ns = nw & ~32'd7;
      list_unlink(nxt, size_class(ns));
      csize += ns;
    end
    if (!pw[0]) begin
      ps = pw & ~32'd7;
      list_unlink(bp - ps, size_class(ps));
      csize += ps;
      bp -= ps;
    end
    tag_wr(bp - 4, csize);
    tag_wr(bp + csize - 8, csize);
    list_push(size_class(csize), bp);
    return bp;
  endfunction

  function automatic int unsigned extend_heap(int unsigned bytes);
    int unsigned bp;
    bp = brk;
    if (bp == 0 || bytes > HEAP - bp) return 0;
    tag_wr(bp - 4, bytes);
    tag_wr(bp + bytes - 8, bytes);
    tag_wr(bp + bytes - 4, 1);
    brk = bp + bytes;
    return merge_free(bp);
  endfunction

  function automatic int unsigned first_fit(int unsigned asize);
    int unsigned budget, bp;
    budget = NWORDS;
    for (int unsigned i = size_class(asize); i < NCLASS; i++) begin
      bp = list_head[i];
      while (bp != 0 && budget != 0) begin
        budget--;
        if ((tag_rd(bp - 4) & ~32'd7) >= asize) return bp;
        bp = tag_rd(bp + 4);
      end
    end
    return 0;
  endfunction

  function automatic void carve(int unsigned bp, int unsigned asize);
    int unsigned csize, rest;
    csize = tag_rd(bp - 4) & ~32'd7;
    list_unlink(bp, size_class(csize));
    if (csize >= asize + 16) begin
      rest = bp + asize;
      tag_wr(bp - 4, asize | 1);
      tag_wr(bp + asize - 8, asize | 1);
      tag_wr(rest - 4, csize - asize);
      tag_wr(rest + csize - asize - 8, csize - asize);
      void'(merge_free(rest));
    end else begin
      tag_wr(bp - 4, csize | 1);
      tag_wr(bp + csize - 8, csize | 1);
    end
  endfunction

  // a free passes every sanity check; without it the free is dropped
  function automatic bit free_is_sound(int unsigned a);
    int unsigned h, s;
    if ((a & 7) != 0 || a < 16 || a >= brk) return 0;
    h = tag_rd(a - 4);
    s = h & ~32'd7;
    if (!h[0] || s < 16 || s > brk - a) return 0;
    return tag_rd(a + s - 8) == h;
  endfunction

  // true when a free of a would read a tag word never written since reset
  function automatic bit free_hits_blank(int unsigned a);
    int unsigned h, s;
    if ((a & 7) != 0 || a < 16 || a >= brk) return 0;
    if (!tag_written[((a - 4) >> 2) % NWORDS]) return 1;
    h = tag_rd(a - 4);
    s = h & ~32'd7;
    if (!h[0] || s < 16 || s > brk - a) return 0;
    return !tag_written[((a + s - 8) >> 2) % NWORDS];
  endfunction

  function automatic alloc_result_t heap_step(logic [OPC_W-1:0] op,
                                              int unsigned req, int unsigned a);
    alloc_result_t r;
    int unsigned asize, bp;
    r = '{addr: '0, status: ST_OK};
    if (op == OP_INIT) begin
      brk = 0;
      foreach (list_head[i]) list_head[i] = 0;
      tag_wr(0, 0);
      tag_wr(4, PROLOGUE_TAG);
      tag_wr(8, PROLOGUE_TAG);
      tag_wr(12, EPILOGUE_TAG);
      brk = 16;
      if (extend_heap(256) == 0) r.status = ST_NOSPACE;
    end else if (op == OP_ALLOC) begin
      if (req == 0) r.status = ST_ZERO;
      else if (brk == 0) r.status = ST_NOSPACE;
      else begin
        asize = (req + 15) & ~32'd7;
        bp = first_fit(asize);
        if (bp == 0) bp = extend_heap(asize > 64 ? asize : 64);
        if (bp == 0) r.status = ST_NOSPACE;
        else begin
          carve(bp, asize);
          r.addr = bp[15:0];
        end
      end
    end else if (op == OP_FREE) begin
      if (free_is_sound(a)) begin
        tag_wr(a - 4, tag_rd(a - 4) & ~32'd7);
        tag_wr(a + (tag_rd(a - 4) & ~32'd7) - 8, tag_rd(a - 4));
        void'(merge_free(a));
      end
    end
    return r;
  endfunction

  // ----------------------------------------------------------------- driving
  // One item per call. Any idle gap comes first, so valid stays high between
  // back-to-back items and is only touched once per falling edge.
  task automatic send_item(logic [OPC_W-1:0] op, int unsigned req, int unsigned a);
    alloc_result_t r;
    int gap;
    if (!calm && $urandom_range(99) < 31) begin
      gap = $urandom_range(1, 4);
      @(negedge clk);
      in_valid <= 1'b0;
      repeat (gap - 1) @(negedge clk);
    end
    @(negedge clk);
    in_valid         <= 1'b1;
    in_opcode        <= op;
    in_request_bytes <= req[REQ_W-1:0];
    in_block_address <= a[ADDR_W-1:0];
    do @(posedge clk); while (in_stall);
    r = heap_step(op, req, a);
    pending_results.push_back(r);
    if (op == OP_ALLOC && r.status == ST_OK) live_blocks.push_back(r.addr);
    if (op == OP_INIT) live_blocks.delete();
  endtask

  // hold the sender back until every outstanding result has come back
  task automatic drain();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_results.size() != 0) @(negedge clk);
  endtask

  task automatic free_live(int idx);
    logic [15:0] a;
    a = live_blocks[idx];
    live_blocks.delete(idx);
    send_item(OP_FREE, 0, a);
  endtask

  // receiver stall at the falling edge
  always @(negedge clk) begin
    if (!rst_n) out_stall <= 1'b0;
    else out_stall <= !calm && ($urandom_range(99) < 31);
  end

  // result checker
  always @(posedge clk) begin
    alloc_result_t e;
    if (rst_n && out_valid && !out_stall) begin
      if (pending_results.size() == 0) begin
        $error("result with no expectation: payload_address %0d status %0d",
               out_payload_address, out_status);
        errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_payload_address !== e.addr) begin
          $error("payload_address: expected %0d, got %0d", e.addr, out_payload_address);
          errors++;
        end
        if (out_status !== e.status) begin
          $error("status: expected %0d, got %0d", e.status, out_status);
          errors++;
        end
      end
    end
  end

  // ------------------------------------------------------------------- tests
  // Before the first init: alloc fails, free and opcode 3 are ignored.
  task automatic test_before_init();
    send_item(OP_ALLOC, 24, 0);
    send_item(OP_ALLOC, 0, 0);
    send_item(OP_FREE, 0, 16);
    send_item(2'd3, 17'h1ffff, 16'hffff);
  endtask

  // Field extremes, split / no-split, bad frees, double free, coalescing.
  task automatic test_directed();
    logic [15:0] a0, a1, a2;
    send_item(OP_INIT, 0, 0);
    send_item(OP_ALLOC, 1, 0);
    send_item(OP_ALLOC, 65536, 0);            // beyond capacity
    send_item(OP_ALLOC, 0, 0);                // refused
    send_item(OP_ALLOC, 100, 0);
    send_item(OP_ALLOC, 200, 0);              // takes the remainder whole or grows
    a0 = live_blocks[0]; a1 = live_blocks[1]; a2 = live_blocks[2];
    send_item(OP_FREE, 0, a0 + 4);            // misaligned
    send_item(OP_FREE, 0, 8);                 // below 16
    send_item(OP_FREE, 0, 16'hfff8);          // past the break
    send_item(OP_FREE, 0, a1);
    send_item(OP_FREE, 0, a1);                // double free
    send_item(OP_FREE, 0, a0);                // merges with the next block
    send_item(OP_FREE, 0, a2);
    live_blocks.delete();
    send_item(OP_ALLOC, 4000, 0);             // forces growth
    send_item(2'd3, 0, 0);
    send_item(OP_INIT, 0, 0);                 // fresh heap
    drain();
  endtask

  // Fill the heap with big blocks until growth fails, then release everything.
  task automatic test_exhaust();
    calm = 1'b1;
    send_item(OP_INIT, 0, 0);
    repeat (20) send_item(OP_ALLOC, 4088, 0);
    send_item(OP_ALLOC, 65535, 0);
    while (live_blocks.size() != 0) free_live($urandom_range(live_blocks.size() - 1));
    send_item(OP_ALLOC, 60000, 0);            // whole heap merged back
    calm = 1'b0;
    drain();
  endtask

  function automatic int unsigned pick_request();
    int unsigned p;
    p = $urandom_range(99);
    if (p < 3) return 0;
    if (p < 80) return $urandom_range(1, 256);
    if (p < 96) return $urandom_range(257, 4096);
    return $urandom_range(4097, 65536);
  endfunction

  task automatic test_random(int n);
    int unsigned p, a;
    for (int i = 0; i < n; i++) begin
      calm = (i >= n / 3 && i < n / 3 + 150);
      p = $urandom_range(999);
      if (p < 10) send_item(OP_INIT, 0, 0);
      else if (p < 40) send_item(2'd3, $urandom_range(17'h1ffff), $urandom_range(16'hffff));
      else if (p < 90) begin
        // random address: only sent when it is rejected without touching a blank
        // tag word; a forged block that passes the checks would corrupt the lists
        a = (p < 60) ? ($urandom_range(16'hffff) & ~32'd7) : $urandom_range(16'hffff);
        if (!free_hits_blank(a) && !free_is_sound(a)) send_item(OP_FREE, 0, a);
        else send_item(OP_ALLOC, pick_request(), 0);
      end else if (p < 500 && live_blocks.size() != 0) free_live($urandom_range(live_blocks.size() - 1));
      else send_item(OP_ALLOC, pick_request(), 0);
      if (i == n / 2) drain();
    end
    calm = 1'b0;
  endtask

  // --------------------------------------------------------------------- main
  initial begin
    clk = 1'b0;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_opcode = OP_INIT;
    in_request_bytes = '0;
    in_block_address = '0;
    out_stall = 1'b0;
    errors = 0;
    calm = 1'b0;
    brk = 0;
    foreach (list_head[i]) list_head[i] = 0;
    foreach (shadow_tags[i]) begin
      shadow_tags[i] = '0;
      tag_written[i] = 1'b0;
    end
    repeat (4) @(negedge clk);
    rst_n <= 1'b1;

    test_before_init();
    test_directed();
    test_exhaust();
    test_random(1700);
    drain();
    repeat (200) @(negedge clk);

    if (errors == 0 && pending_results.size() == 0) $display("TB_OK");
    else $display("TB_ERROR");
    $finish;
  end

  // Watchdog.
  initial begin
    #20000000;
    $display("TB_ERROR");
    $finish;
  end

endmodule
